/* src/crq_pkg.sv */
package crq_pkg;

    localparam int IDX_W        = 4;   // ring index width
    localparam int CAP_W        = 4;   // capacity register width
    localparam int FIELD_W      = 32;  // width of each record field
    localparam int REC_W        = 2 * FIELD_W;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int SLOTS_DEF    = 16;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int IN_TDATA_W   = 64;  // roll_in, marks_in
    localparam int OUT_TDATA_W  = 72;  // roll_out, marks_out, is_empty, is_full, pad

    localparam logic [CAP_W-1:0]   CAPACITY_RST = 4'd15;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ENQ       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK_OLD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK_NEW  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic latch_req;  // capture the incoming word
        logic exec;       // run the request against the ring
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;   // output register empty or draining this cycle
    } t_dp_stat;

    // Step an index around a ring of cap+1 slots.
    function automatic logic [IDX_W-1:0] f_adv(input logic [IDX_W-1:0] idx,
                                                input logic [CAP_W-1:0] cap);
        logic [IDX_W:0] nxt;
        logic [IDX_W:0] ring;
        nxt  = {1'b0, idx} + 1'b1;
        ring = {1'b0, cap} + 1'b1;
        return (nxt >= ring) ? '0 : nxt[IDX_W-1:0];
    endfunction

endpackage

/* src/crq_ctrl.sv */
module crq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  crq_pkg::t_dp_stat i_stat,
    output crq_pkg::t_dp_cmd  o_cmd
);
    import crq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch_req = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                // hold here while the previous result is still unclaimed
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/crq_dp.sv */
module crq_dp #(
    parameter int SLOTS = crq_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crq_pkg::t_dp_cmd              i_cmd,
    output crq_pkg::t_dp_stat             o_stat,
    input  logic [crq_pkg::CAP_W-1:0]     i_capacity,
    input  logic [crq_pkg::KIND_W-1:0]    i_kind,
    input  logic [crq_pkg::FIELD_W-1:0]   i_roll,
    input  logic [crq_pkg::FIELD_W-1:0]   i_marks,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [crq_pkg::STATUS_W-1:0]  o_status,
    output logic [crq_pkg::FIELD_W-1:0]   o_roll,
    output logic [crq_pkg::FIELD_W-1:0]   o_marks,
    output logic                          o_is_empty,
    output logic                          o_is_full
);
    import crq_pkg::*;

    localparam int AW        = $clog2(SLOTS);
    localparam int IDX_MAX   = (1 << IDX_W) - 1;
    localparam int MOD_STEPS = IDX_MAX / SLOTS;

    // index modulo SLOTS by repeated subtraction (few steps, narrow value)
    function automatic logic [AW-1:0] f_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] v;
        v = idx;
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (v >= SLOTS) begin
                v = v - IDX_W'(SLOTS);
            end
        end
        return AW'(v);
    endfunction

    logic [REC_W-1:0]    r_mem [SLOTS];
    logic [REC_W-1:0]    r_rd_data;

    logic [KIND_W-1:0]   r_kind;
    logic [FIELD_W-1:0]  r_roll;
    logic [FIELD_W-1:0]  r_marks;
    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    r_tail;
    logic [STATUS_W-1:0] r_status;
    logic                r_rec_ok;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FIELD_W-1:0]  r_out_roll;
    logic [FIELD_W-1:0]  r_out_marks;
    logic                r_out_empty;
    logic                r_out_full;

    logic [IDX_W-1:0]    n_head;
    logic [IDX_W-1:0]    n_tail;
    logic [IDX_W-1:0]    adv_head;
    logic [IDX_W-1:0]    adv_tail;
    logic [IDX_W-1:0]    rd_idx;
    logic [STATUS_W-1:0] n_status;
    logic                wr_en;
    logic                q_empty;
    logic                q_full;

    assign adv_head = f_adv(r_head, i_capacity);
    assign adv_tail = f_adv(r_tail, i_capacity);
    assign q_empty  = (r_head == r_tail);
    assign q_full   = (adv_tail == r_head);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        rd_idx   = adv_head;
        if (r_kind == KIND_ENQ) begin
            if (q_full) begin
                n_status = ST_FULL;
            end else begin
                n_tail = adv_tail;
                wr_en  = 1'b1;
            end
        end else if (q_empty) begin
            n_status = ST_EMPTY;
        end else begin
            case (r_kind)
                KIND_DEQ:      n_head = adv_head;
                KIND_PEEK_NEW: rd_idx = r_tail;
                default:       rd_idx = adv_head;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_kind  <= i_kind;
            r_roll  <= i_roll;
            r_marks <= i_marks;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_rec_ok  <= (n_status == ST_DONE) && (r_kind != KIND_ENQ);
            r_rd_data <= r_mem[f_slot(rd_idx)];
            if (wr_en) begin
                r_mem[f_slot(adv_tail)] <= {r_marks, r_roll};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // output register; flags come from the indices already updated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_roll   <= r_rec_ok ? r_rd_data[FIELD_W-1:0] : '0;
            r_out_marks  <= r_rec_ok ? r_rd_data[REC_W-1:FIELD_W] : '0;
            r_out_empty  <= q_empty;
            r_out_full   <= q_full;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_roll          = r_out_roll;
    assign o_marks         = r_out_marks;
    assign o_is_empty      = r_out_empty;
    assign o_is_full       = r_out_full;

endmodule

/* src/circular_record_queue_unit.sv */
// Circular record queue with peek.
// Request words arrive on the slave stream: tuser carries the request kind
// (enqueue, dequeue, peek oldest, peek newest), tdata the two record fields
// used by an enqueue. Every request word produces exactly one result word on
// the master stream: tuser carries the status (done, rejected full, rejected
// empty), tdata the record read (zero when nothing was read) plus the empty
// and full flags as they stand after the request.
// Capacity (0..15 records) is set through the APB register at address 0;
// the ring uses capacity+1 slots, one always spare. Change it only while
// the queue is idle and empty.
// Timing: a request is taken in the idle cycle, runs against the ring in the
// next (index update, record write or synchronous record read), and its
// result is loaded into the output register once that register is free.
// A new request is taken only after the last result is loaded, as the
// controller's three states (take, execute, load result) run in turn.
// The output register lets a new request be accepted while the last result
// waits; if the receiver still stalls when the next result is ready, the
// controller holds it and no further request is accepted.
// Reset clears both indices (queue empty) and sets capacity to 15; record
// memory is not cleared, nothing is read before it is written.
module circular_record_queue_unit #(
    parameter int SLOTS = crq_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream: request words
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [crq_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // [31:0] roll_in, [63:32] marks_in
    input  logic [crq_pkg::KIND_W-1:0]        i_s_tuser,  // [1:0] kind
    // master stream: result words
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [crq_pkg::OUT_TDATA_W-1:0]   o_m_tdata,  // [31:0] roll_out, [63:32] marks_out,
                                                          // [64] is_empty, [65] is_full, zero pad
    output logic [crq_pkg::STATUS_W-1:0]      o_m_tuser,  // [1:0] status
    // APB configuration port
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [crq_pkg::PADDR_W-1:0]       i_paddr,
    input  logic [crq_pkg::PDATA_W-1:0]       i_pwdata,
    output logic [crq_pkg::PDATA_W-1:0]       o_prdata,
    output logic                              o_pready
);
    import crq_pkg::*;

    logic [CAP_W-1:0]    r_capacity;
    logic                cfg_wr;
    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic [STATUS_W-1:0] out_status;
    logic [FIELD_W-1:0]  out_roll;
    logic [FIELD_W-1:0]  out_marks;
    logic                out_empty;
    logic                out_full;

    // ---------------- configuration register ----------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
        end else if (cfg_wr) begin
            r_capacity <= i_pwdata[CAP_W-1:0];
        end
    end

    assign o_prdata = (i_paddr == ADDR_CAPACITY) ? PDATA_W'(r_capacity) : '0;

    // ---------------- controller ----------------
    crq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // ---------------- datapath: indices, record memory, output register ----
    crq_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_capacity  (r_capacity),
        .i_kind      (i_s_tuser),
        .i_roll      (i_s_tdata[FIELD_W-1:0]),
        .i_marks     (i_s_tdata[REC_W-1:FIELD_W]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_status    (out_status),
        .o_roll      (out_roll),
        .o_marks     (out_marks),
        .o_is_empty  (out_empty),
        .o_is_full   (out_full)
    );

    assign o_m_tuser = out_status;
    assign o_m_tdata = {6'b0, out_full, out_empty, out_marks, out_roll};

    // ---------------- assertions ----------------
    a_full_reject_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_FULL)) |-> o_m_tdata[REC_W+1])
        else $error("full rejection without full flag");

    a_empty_reject_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_EMPTY)) |-> o_m_tdata[REC_W])
        else $error("empty rejection without empty flag");

    a_reject_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_DONE)) |-> (o_m_tdata[REC_W-1:0] == '0))
        else $error("rejected request returned a record");

endmodule
